// File: sv/ellipse_scanline_span_macros.svh
// Assertion helpers for the ellipse span block.
`ifndef ELLIPSE_SCANLINE_SPAN_MACROS_SVH
`define ELLIPSE_SCANLINE_SPAN_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset gating.
`define ESS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under reset gating.
`define ESS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ESS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define ESS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: sv/esspan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esspan_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 15;
    localparam int HALF_BITS  = DIM_BITS - 1;
    localparam int SQ_BITS    = 2 * HALF_BITS;
    localparam int REM_BITS   = SQ_BITS + 1;
    localparam int DIV_STEPS  = 31;
    localparam int Q_BITS     = DIV_STEPS;
    localparam int SQRT_STEPS = 16;
    localparam int RES_BITS   = 32;
    localparam int ROOT_BITS  = 16;
    localparam int OUT_SHIFT  = 15;
    localparam int PROD_BITS  = HALF_BITS + ROOT_BITS;

    // One input transfer
    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_left;
        logic signed [COORD_BITS-1:0] box_top;
        logic        [DIM_BITS-1:0]   box_width;
        logic        [DIM_BITS-1:0]   box_height;
        logic        [DIM_BITS-1:0]   row_index;
    } t_in;

    // One result transfer
    typedef struct packed {
        logic signed [COORD_BITS-1:0] scan_y;
        logic                         row_empty;
        logic signed [COORD_BITS-1:0] span_left;
        logic signed [COORD_BITS-1:0] span_right;
    } t_out;

    // Values carried alongside the arithmetic pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0] scan_y;
        logic [COORD_BITS-1:0] cx;
        logic [HALF_BITS-1:0]  a;
        logic                  empty;
    } t_side;

endpackage

`default_nettype wire

// File: sv/esspan_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined floor square root, one result bit per stage.
module esspan_sqrt (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic                             i_valid,
    input  wire esspan_pkg::t_side                i_side,
    input  wire logic [esspan_pkg::Q_BITS-1:0]    i_q,
    output logic                                  o_valid,
    output esspan_pkg::t_side                     o_side,
    output logic [esspan_pkg::ROOT_BITS-1:0]      o_root
);

    localparam int N  = esspan_pkg::SQRT_STEPS;
    localparam int QB = esspan_pkg::Q_BITS;
    localparam int RB = esspan_pkg::RES_BITS;

    logic                r_vld  [0:N-1];
    esspan_pkg::t_side   r_side [0:N-1];
    logic [QB-1:0]       r_v    [0:N-1];
    logic [RB-1:0]       r_res  [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [RB-1:0] BIT = RB'(1) << (2 * (N - 1 - k));
        logic              c_vld;
        esspan_pkg::t_side c_side;
        logic [QB-1:0]     c_v;
        logic [RB-1:0]     c_res;
        logic [RB-1:0]     sum;
        logic              ge;

        if (k == 0) begin : g_first
            assign c_vld  = i_valid;
            assign c_side = i_side;
            assign c_v    = i_q;
            assign c_res  = '0;
        end else begin : g_next
            assign c_vld  = r_vld[k-1];
            assign c_side = r_side[k-1];
            assign c_v    = r_v[k-1];
            assign c_res  = r_res[k-1];
        end

        // Trial subtract of res + bit
        assign sum = c_res + BIT;
        assign ge  = {{(RB-QB){1'b0}}, c_v} >= sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[k] <= c_side;
                r_v[k]    <= ge ? (c_v - sum[QB-1:0]) : c_v;
                r_res[k]  <= ge ? ((c_res >> 1) + BIT) : (c_res >> 1);
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_side  = r_side[N-1];
    assign o_root  = r_res[N-1][esspan_pkg::ROOT_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/ellipse_scanline_span.sv
// Span of one row of an axis-aligned ellipse. Each transfer names a bounding
// box and a row; the result gives the scanline y, an empty flag and the left
// and right span edges. The block is a fixed pipeline of 51 register stages
// (squares, remainder, a 31-stage restoring divider, a 16-stage square root,
// the multiply and the output register). One item is taken every cycle while
// the pipeline advances. The whole pipeline advances together whenever the
// output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

`include "ellipse_scanline_span_macros.svh"

module ellipse_scanline_span (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire esspan_pkg::t_in   i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output esspan_pkg::t_out       o_data
);

    localparam int CB = esspan_pkg::COORD_BITS;
    localparam int HB = esspan_pkg::HALF_BITS;
    localparam int SB = esspan_pkg::SQ_BITS;
    localparam int RB = esspan_pkg::REM_BITS;
    localparam int DN = esspan_pkg::DIV_STEPS;
    localparam int QB = esspan_pkg::Q_BITS;
    localparam int PB = esspan_pkg::PROD_BITS;

    logic w_adv;
    logic r_out_valid;

    // Pipeline moves when the output register is free or taken
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // Front stage: half axes, squares and early empty checks
    logic                     c_f_empty;
    logic [HB-1:0]            c_a;
    logic [HB-1:0]            c_b;
    logic signed [CB-1:0]     c_dy;
    logic [esspan_pkg::DIM_BITS-1:0] c_dy_abs;
    esspan_pkg::t_side        c_f_side;

    assign c_a       = i_data.box_width[esspan_pkg::DIM_BITS-1:1];
    assign c_b       = i_data.box_height[esspan_pkg::DIM_BITS-1:1];
    assign c_dy      = $signed({1'b0, i_data.row_index}) - $signed({2'b00, c_b});
    assign c_dy_abs  = c_dy[CB-1] ? esspan_pkg::DIM_BITS'(-c_dy)
                                  : c_dy[esspan_pkg::DIM_BITS-1:0];
    assign c_f_empty = (i_data.box_width == '0) || (c_b == '0) ||
                       (i_data.row_index >= i_data.box_height);

    assign c_f_side.scan_y = i_data.box_top + $signed({1'b0, i_data.row_index});
    assign c_f_side.cx     = i_data.box_left + $signed({2'b00, c_a});
    assign c_f_side.a      = c_a;
    assign c_f_side.empty  = c_f_empty;

    logic              r_f_valid;
    esspan_pkg::t_side r_f_side;
    logic [SB-1:0]     r_f_b2;
    logic [SB+1:0]     r_f_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_adv) begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_side <= c_f_side;
            r_f_b2   <= c_b * c_b;
            r_f_dy2  <= c_dy_abs * c_dy_abs;
        end
    end

    // Remainder stage: b*b - dy*dy, negative means empty
    logic signed [SB+2:0] c_rem;
    esspan_pkg::t_side    c_r_side;
    assign c_rem = $signed({3'b000, r_f_b2}) - $signed({1'b0, r_f_dy2});

    always_comb begin
        c_r_side       = r_f_side;
        c_r_side.empty = r_f_side.empty || c_rem[SB+2];
    end

    logic              r_r_valid;
    esspan_pkg::t_side r_r_side;
    logic [RB-1:0]     r_r_rem;
    logic [SB-1:0]     r_r_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_r_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_side <= c_r_side;
            r_r_rem  <= c_rem[RB-1:0];
            r_r_b2   <= r_f_b2;
        end
    end

    // Restoring divider: one quotient bit of rem * 2^30 / b2 per stage
    logic              r_dv [0:DN-1];
    esspan_pkg::t_side r_ds [0:DN-1];
    logic [RB-1:0]     r_dr [0:DN-1];
    logic [SB-1:0]     r_dd [0:DN-1];
    logic [QB-1:0]     r_dq [0:DN-1];

    for (genvar i = 0; i < DN; i++) begin : g_div
        logic              c_v;
        esspan_pkg::t_side c_s;
        logic [RB-1:0]     c_r;
        logic [SB-1:0]     c_d;
        logic [QB-1:0]     c_q;
        logic [RB:0]       t;
        logic              ge;

        if (i == 0) begin : g_first
            assign c_v = r_r_valid;
            assign c_s = r_r_side;
            assign c_r = r_r_rem;
            assign c_d = r_r_b2;
            assign c_q = '0;
            assign t   = {1'b0, c_r};
        end else begin : g_next
            assign c_v = r_dv[i-1];
            assign c_s = r_ds[i-1];
            assign c_r = r_dr[i-1];
            assign c_d = r_dd[i-1];
            assign c_q = r_dq[i-1];
            assign t   = {c_r, 1'b0};
        end

        assign ge = t >= {2'b00, c_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[i] <= 1'b0;
            end else if (w_adv) begin
                r_dv[i] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ds[i] <= c_s;
                r_dr[i] <= ge ? RB'(t - {2'b00, c_d}) : t[RB-1:0];
                r_dd[i] <= c_d;
                r_dq[i] <= {c_q[QB-2:0], ge};
            end
        end
    end

    // Square root pipeline
    logic              w_s_valid;
    esspan_pkg::t_side w_s_side;
    logic [esspan_pkg::ROOT_BITS-1:0] w_s_root;

    esspan_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_dv[DN-1]),
        .i_side  (r_ds[DN-1]),
        .i_q     (r_dq[DN-1]),
        .o_valid (w_s_valid),
        .o_side  (w_s_side),
        .o_root  (w_s_root)
    );

    // Multiply stage: a * root
    logic              r_m_valid;
    esspan_pkg::t_side r_m_side;
    logic [PB-1:0]     r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_side <= w_s_side;
            r_m_prod <= w_s_side.a * w_s_root;
        end
    end

    // Output stage: edges and final empty check
    logic [PB-esspan_pkg::OUT_SHIFT-1:0] c_half;
    logic [CB-1:0]                       c_half_w;
    logic                                c_empty;
    esspan_pkg::t_out                    n_out;
    esspan_pkg::t_out                    r_out;

    assign c_half   = r_m_prod[PB-1:esspan_pkg::OUT_SHIFT];
    assign c_half_w = CB'(c_half);
    assign c_empty  = r_m_side.empty || (c_half == '0);

    always_comb begin
        n_out.scan_y     = r_m_side.scan_y;
        n_out.row_empty  = c_empty;
        n_out.span_left  = c_empty ? '0 : (r_m_side.cx - c_half_w);
        n_out.span_right = c_empty ? '0 : (r_m_side.cx + c_half_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    `ESS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_valid && o_data.row_empty, (o_data.span_left == '0) && (o_data.span_right == '0), "empty row with nonzero edges")
    `ESS_ASSERT_NOW(a_span_parity, i_clk, i_rst_n, o_valid && !o_data.row_empty, o_data.span_left[0] == o_data.span_right[0], "span edges differ by an odd amount")
    `ESS_ASSERT_NOW(a_prod_bound, i_clk, i_rst_n, r_m_valid && !r_m_side.empty, r_m_prod[PB-1] == 1'b0, "half span out of range")
    `ESS_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid && $stable(r_out), "stalled result lost")

endmodule

`default_nettype wire

// File: tb/ellipse_scanline_span_tb.sv
`timescale 1ns / 1ps

module ellipse_scanline_span_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM       = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    esspan_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    esspan_pkg::t_out o_data;

    esspan_pkg::t_in  pending_boxes[$];
    esspan_pkg::t_out expected_spans[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   send_wait = 0;
    int   recv_wait = 0;
    bit   stimulus_done = 1'b0;
    bit   in_fire = 1'b0;
    bit   out_fire = 1'b0;

    ellipse_scanline_span dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    // floor square root, bit by bit
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (v >= root + bitpos) begin
                v = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root[31:0];
    endfunction

    // expected span of one row
    function automatic esspan_pkg::t_out row_span(input esspan_pkg::t_in b_in);
        esspan_pkg::t_out r;
        longint w, h, row, a, b, dy, b2, rem, half, cx;
        logic [63:0] q;
        bit blank;
        w = b_in.box_width;
        h = b_in.box_height;
        row = b_in.row_index;
        a = w / 2;
        b = h / 2;
        cx = longint'(b_in.box_left) + a;
        half = 0;
        blank = 1'b0;
        r = '0;
        r.scan_y = 16'(longint'(b_in.box_top) + row);
        if (w == 0 || h == 0 || row >= h || b == 0) begin
            blank = 1'b1;
        end else begin
            dy = row - b;
            b2 = b * b;
            rem = b2 - dy * dy;
            if (rem < 0) begin
                blank = 1'b1;
            end else begin
                q = (64'(rem) << 30) / 64'(b2);
                half = (a * longint'(floor_sqrt(q))) >>> 15;
                if (half == 0) blank = 1'b1;
            end
        end
        r.row_empty = blank;
        if (!blank) begin
            r.span_left  = 16'(cx - half);
            r.span_right = 16'(cx + half);
        end
        return r;
    endfunction

    function automatic esspan_pkg::t_in random_box();
        esspan_pkg::t_in t;
        t.box_left = 16'($urandom);
        t.box_top  = 16'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                t.box_width  = 15'($urandom);
                t.box_height = 15'($urandom);
                t.row_index  = 15'($urandom);
            end
            1, 2: begin
                t.box_width  = 15'($urandom_range(0, 40));
                t.box_height = 15'($urandom_range(0, 40));
                t.row_index  = 15'($urandom_range(0, 45));
            end
            default: begin
                t.box_width  = 15'($urandom_range(1, 32767));
                t.box_height = 15'($urandom_range(2, 32767));
                t.row_index  = 15'($urandom_range(0, t.box_height - 1));
            end
        endcase
        return t;
    endfunction

    function automatic esspan_pkg::t_in make_box(input logic [15:0] l, input logic [15:0] t,
                                                 input logic [14:0] w, input logic [14:0] h,
                                                 input logic [14:0] r);
        esspan_pkg::t_in x;
        x.box_left = l;
        x.box_top = t;
        x.box_width = w;
        x.box_height = h;
        x.row_index = r;
        return x;
    endfunction

    // transfers seen at the last rising edge
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && !o_stall;
        out_fire <= i_rst_n && o_valid && !i_stall;
    end

    // driver: one transfer per queued box, random gap before each
    always @(negedge i_clk) begin
        int gap;
        if (i_rst_n) begin
            if (i_valid && in_fire) begin
                if (send_wait == 0 && pending_boxes.size() > 0 && $urandom_range(0, 1)) begin
                    i_data <= pending_boxes.pop_front();
                    send_wait <= $urandom_range(0, 15);
                end else begin
                    i_valid <= 1'b0;
                    send_wait <= (send_wait == 0) ? 0 : send_wait - 1;
                end
            end else if (!i_valid) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_boxes.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data <= pending_boxes.pop_front();
                    send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                end
            end
            // receiver stall, drawn per result
            if (out_fire) begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
                i_stall <= (gap > 0);
                recv_wait <= (gap > 0) ? gap - 1 : 0;
            end else if (recv_wait > 0) begin
                i_stall <= 1'b1;
                recv_wait <= recv_wait - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        esspan_pkg::t_out exp_span;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_spans.push_back(row_span(i_data));
            if (o_valid && !i_stall) begin
                if (expected_spans.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, o_data);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_span = expected_spans.pop_front();
                    if (o_data.scan_y !== exp_span.scan_y ||
                        o_data.row_empty !== exp_span.row_empty ||
                        o_data.span_left !== exp_span.span_left ||
                        o_data.span_right !== exp_span.span_right) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, exp_span, o_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT && !stimulus_done) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int waited;
        // corner rows: extremes, empty cases, single-row and tiny boxes
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd0, 15'd10, 15'd5));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd10, 15'd0, 15'd0));
        pending_boxes.push_back(make_box(16'h0010, 16'h0020, 15'd10, 15'd10, 15'd10));
        pending_boxes.push_back(make_box(16'h0010, 16'h0020, 15'd10, 15'd1, 15'd0));
        pending_boxes.push_back(make_box(16'h0010, 16'h0020, 15'd1, 15'd10, 15'd5));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd10, 15'd10, 15'd0));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd10, 15'd10, 15'd5));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd11, 15'd11, 15'd10));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'd3, 15'd2, 15'd1));
        pending_boxes.push_back(make_box(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 15'd16383));
        pending_boxes.push_back(make_box(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 15'h7FFE));
        pending_boxes.push_back(make_box(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF));
        pending_boxes.push_back(make_box(16'h7FF0, 16'h0000, 15'h7FFF, 15'd100, 15'd50));
        pending_boxes.push_back(make_box(16'h8000, 16'h7FFF, 15'd2, 15'h7FFF, 15'd16383));
        pending_boxes.push_back(make_box(16'h5555, 16'hAAAA, 15'h2AAA, 15'h5555, 15'h2AAA));
        pending_boxes.push_back(make_box(16'hAAAA, 16'h5555, 15'h5555, 15'h2AAA, 15'h1555));
        pending_boxes.push_back(make_box(16'h0000, 16'h0000, 15'h7FFF, 15'h7FFF, 15'h7FFF));
        for (int i = 0; i < N_RANDOM; i++)
            pending_boxes.push_back(random_box());
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_boxes.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        waited = 0;
        while (expected_spans.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        stimulus_done = 1'b1;
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_spans.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
